>>> rtl/core/totp_pkg.sv
// ----------------------------------------------------------------------------
// TOTP package
// Shared types, constants and helper functions of the one-time password engine.
// ----------------------------------------------------------------------------
package totp_pkg;

	localparam int KEY_BYTES_DEF = 64;
	localparam int QUEUE_DEPTH = 2;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_GEN  = 1'b1;

	localparam logic [1:0] CFG_KEY_LENGTH = 2'd0;
	localparam logic [1:0] CFG_DIGITS     = 2'd1;
	localparam logic [1:0] CFG_PERIOD     = 2'd2;

	typedef struct packed {
		logic        action;
		logic [3:0]  key_index;
		logic [31:0] key_word;
		logic [62:0] timestamp_ns;
	} in_item_t;

	typedef struct packed {
		logic [26:0] password;
		logic        status;
	} out_item_t;

	// Classified item handed from the front part to the back part.
	typedef struct packed {
		logic        load;
		logic        bad;
		logic [3:0]  key_index;
		logic [31:0] key_word;
		logic [62:0] timestamp_ns;
	} job_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		rotl = (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [31:0] pow10(input logic [3:0] d);
		case (d)
			4'd1: pow10 = 32'd10;
			4'd2: pow10 = 32'd100;
			4'd3: pow10 = 32'd1000;
			4'd4: pow10 = 32'd10000;
			4'd5: pow10 = 32'd100000;
			4'd6: pow10 = 32'd1000000;
			4'd7: pow10 = 32'd10000000;
			4'd8: pow10 = 32'd100000000;
			default: pow10 = 32'd1;
		endcase
	endfunction

endpackage

>>> rtl/core/totp_front.sv
// ----------------------------------------------------------------------------
// TOTP front end
// Accepts items, classifies them and queues them in order for the back end.
// ----------------------------------------------------------------------------
module totp_front import totp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  in_item_t    item,
	input  logic [3:0]  digit_count,
	input  logic [31:0] period_seconds,
	output logic        busy,
	output logic        job_valid,
	output job_t        job,
	input  logic        job_take
);

	localparam int QW = $clog2(QUEUE_DEPTH);

	job_t           q_mem_q [QUEUE_DEPTH];
	logic [QW-1:0]  wr_q, rd_q;
	logic [QW:0]    cnt_q;
	logic           accept, push, pop, bad;

	assign busy     = (cnt_q == (QW+1)'(QUEUE_DEPTH)) ? 1'b1 : 1'b0;
	assign accept   = start && !busy;
	assign push     = accept;
	assign pop      = job_take && job_valid;
	assign bad      = (digit_count < 4'd1) || (digit_count > 4'd8) || (period_seconds == 32'd0);
	assign job_valid = cnt_q != '0;
	assign job      = q_mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_q] <= '{load: item.action == ACT_LOAD, bad: bad,
				key_index: item.key_index, key_word: item.key_word,
				timestamp_ns: item.timestamp_ns};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (QW+1)'(push) - (QW+1)'(pop);
		end
	end

endmodule

>>> rtl/core/totp_back.sv
// ----------------------------------------------------------------------------
// TOTP back end
// Divides the timestamp, runs four SHA-1 compressions, truncates and reduces.
// ----------------------------------------------------------------------------
module totp_back import totp_pkg::*; #(
	parameter int KEY_BYTES = KEY_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [6:0]  key_length,
	input  logic [3:0]  digit_count,
	input  logic [31:0] period_seconds,
	input  logic        job_valid,
	input  job_t        job,
	output logic        job_take,
	output logic        done,
	output out_item_t   result
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MUL   = 4'd1;
	localparam logic [3:0] ST_DIV   = 4'd2;
	localparam logic [3:0] ST_LOAD  = 4'd3;
	localparam logic [3:0] ST_ROUND = 4'd4;
	localparam logic [3:0] ST_ADD   = 4'd5;
	localparam logic [3:0] ST_TRUNC = 4'd6;
	localparam logic [3:0] ST_MOD   = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;
	localparam logic [6:0] KB = 7'(KEY_BYTES);

	logic [3:0]  st_q;
	logic [31:0] key_q [16];
	logic [31:0] w_q [16];
	logic [31:0] h_q [5];
	logic [31:0] inner_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [6:0]  rnd_q;
	logic [1:0]  blk_q;
	logic [62:0] rem_q, quo_q;
	logic [61:0] div_q;
	logic [5:0]  bit_q;
	logic [30:0] hv_q;
	logic [31:0] m_q;
	logic [63:0] dsub;
	logic [6:0]  len;
	logic [31:0] wnew, wcur, f, k, t;
	logic [31:0] blk [16];
	logic [7:0]  dbytes [20];
	logic [3:0]  off;
	logic        key_we;

	assign len = (key_length > KB) ? KB : key_length;

	always_comb begin
		logic [7:0] pad;
		pad = (blk_q == 2'd0) ? 8'h36 : 8'h5C;
		for (int j = 0; j < 16; j++) begin
			blk[j] = '0;
		end
		if (blk_q[0] == 1'b0) begin
			for (int j = 0; j < 16; j++) begin
				for (int b = 0; b < 4; b++) begin
					blk[j][31-8*b -: 8] = ((7'(4*j+b) < len) ? key_q[j][31-8*b -: 8] : 8'h00) ^ pad;
				end
			end
		end else if (blk_q == 2'd1) begin
			blk[0]  = {1'b0, quo_q[62:32]};
			blk[1]  = quo_q[31:0];
			blk[2]  = 32'h80000000;
			blk[15] = 32'd576;
		end else begin
			for (int j = 0; j < 5; j++) blk[j] = inner_q[j];
			blk[5]  = 32'h80000000;
			blk[15] = 32'd672;
		end
	end

	assign wnew = rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);
	assign wcur = (rnd_q < 7'd16) ? w_q[0] : wnew;

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q); k = 32'h5A827999;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q; k = 32'h6ED9EBA1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = 32'h8F1BBCDC;
		end else begin
			f = b_q ^ c_q ^ d_q; k = 32'hCA62C1D6;
		end
	end
	assign t = rotl(a_q, 5) + f + e_q + k + wcur;

	always_comb begin
		for (int i = 0; i < 20; i++) dbytes[i] = h_q[i/4][31-8*(i%4) -: 8];
	end
	assign off  = dbytes[19][3:0];

	// Trial subtraction of the long division: the partial remainder takes the
	// next dividend bit from the top of the quotient shift register.
	assign dsub = {1'b0, rem_q[61:0], quo_q[62]} - {2'b00, div_q};

	assign job_take = (st_q == ST_IDLE) && job_valid;
	assign key_we   = job_take && job.load;

	always_ff @(posedge clk) begin
		if (key_we) key_q[job.key_index] <= job.key_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (job_valid && !job.load) begin
						if (job.bad) begin
							result <= '{password: '0, status: 1'b1};
							done   <= 1'b1;
						end else begin
							rem_q <= '0;
							quo_q <= job.timestamp_ns;
							st_q  <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					div_q <= 62'(period_seconds) * 62'd1000000000;
					bit_q <= 6'd62;
					st_q  <= ST_DIV;
				end
				ST_DIV: begin
					// Restoring division, one quotient bit a cycle.
					if (!dsub[63]) begin
						rem_q <= dsub[62:0];
						quo_q <= {quo_q[61:0], 1'b1};
					end else begin
						rem_q <= {rem_q[61:0], quo_q[62]};
						quo_q <= {quo_q[61:0], 1'b0};
					end
					if (bit_q == 6'd0) begin
						blk_q <= 2'd0;
						st_q  <= ST_LOAD;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				ST_LOAD: begin
					for (int j = 0; j < 16; j++) w_q[j] <= blk[j];
					if (blk_q[0] == 1'b0) begin
						a_q <= 32'h67452301; b_q <= 32'hEFCDAB89; c_q <= 32'h98BADCFE;
						d_q <= 32'h10325476; e_q <= 32'hC3D2E1F0;
						h_q[0] <= 32'h67452301; h_q[1] <= 32'hEFCDAB89;
						h_q[2] <= 32'h98BADCFE; h_q[3] <= 32'h10325476;
						h_q[4] <= 32'hC3D2E1F0;
					end else begin
						a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2];
						d_q <= h_q[3]; e_q <= h_q[4];
					end
					rnd_q <= '0;
					st_q  <= ST_ROUND;
				end
				ST_ROUND: begin
					for (int j = 0; j < 15; j++) w_q[j] <= w_q[j+1];
					w_q[15] <= wcur;
					e_q <= d_q; d_q <= c_q; c_q <= rotl(b_q, 30); b_q <= a_q; a_q <= t;
					if (rnd_q == 7'd79) st_q <= ST_ADD;
					rnd_q <= rnd_q + 1'b1;
				end
				ST_ADD: begin
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q; h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q; h_q[4] <= h_q[4] + e_q;
					if (blk_q == 2'd1) begin
						inner_q[0] <= h_q[0] + a_q; inner_q[1] <= h_q[1] + b_q;
						inner_q[2] <= h_q[2] + c_q; inner_q[3] <= h_q[3] + d_q;
						inner_q[4] <= h_q[4] + e_q;
					end
					blk_q <= blk_q + 1'b1;
					st_q  <= (blk_q == 2'd3) ? ST_TRUNC : ST_LOAD;
				end
				ST_TRUNC: begin
					hv_q  <= {dbytes[5'(off)][6:0], dbytes[5'(off)+5'd1],
						dbytes[5'(off)+5'd2], dbytes[5'(off)+5'd3]};
					m_q   <= pow10(digit_count);
					div_q <= '0;
					bit_q <= 6'd30;
					st_q  <= ST_MOD;
				end
				ST_MOD: begin
					// Remainder by shift and subtract, one bit a cycle.
					if (({32'd0, m_q} << bit_q) <= {33'd0, hv_q}) begin
						hv_q <= 31'({33'd0, hv_q} - ({32'd0, m_q} << bit_q));
					end
					if (bit_q == 6'd0) st_q <= ST_OUT;
					else bit_q <= bit_q - 1'b1;
				end
				ST_OUT: begin
					result <= '{password: hv_q[26:0], status: 1'b0};
					done   <= 1'b1;
					st_q   <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/totp_hmac_sha1_generator_top.sv
// ----------------------------------------------------------------------------
// TOTP HMAC-SHA1 generator
// Time-based one-time password engine with key store and settings port.
// ----------------------------------------------------------------------------
// Usage: an item is accepted when start is high and busy is low. A load item
// writes one 32-bit key word and gives no result. A generate item queues a
// job; the back end divides the timestamp by the period in nanoseconds
// (one quotient bit a cycle), runs four SHA-1 compressions of 80 rounds
// each through one shared round unit, then truncates and reduces modulo
// ten to the digit count. An invalid setting is answered once its job
// leaves the queue, with status high and a zero password.
// Both kinds of item pass in order through a two-entry queue, so a load
// never disturbs a password that is still being computed.
// Results appear for one cycle with done high; the receiver cannot stall.
// Busy rises only while the two-entry item queue is full.
// Settings are written through cfg_valid/cfg_ready; the user must write them
// only while idle; the block does not enforce it. Reset returns key_length
// 0, digit_count 6 and period_seconds 30; the key store has no reset value.
// ----------------------------------------------------------------------------
module totp_hmac_sha1_generator_top import totp_pkg::*; #(
	parameter int KEY_BYTES = KEY_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_item_t    item,
	output logic        done,
	output out_item_t   result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [6:0]  key_length_q;
	logic [3:0]  digit_count_q;
	logic [31:0] period_q;
	logic        job_valid, job_take;
	job_t        job;

	assign cfg_ready = 1'b1;

	// The settings registers are written straight from the port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q  <= 7'd0;
			digit_count_q <= 4'd6;
			period_q      <= 32'd30;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_KEY_LENGTH: key_length_q  <= cfg_data[6:0];
				CFG_DIGITS:     digit_count_q <= cfg_data[3:0];
				CFG_PERIOD:     period_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	totp_front u_front (
		.clk, .arst_n, .start, .item,
		.digit_count(digit_count_q), .period_seconds(period_q),
		.busy, .job_valid, .job, .job_take
	);

	totp_back #(.KEY_BYTES(KEY_BYTES)) u_back (
		.clk, .arst_n,
		.key_length(key_length_q), .digit_count(digit_count_q),
		.period_seconds(period_q), .job_valid, .job, .job_take, .done, .result
	);

endmodule
